@@ sv/pfq_pkg.sv @@
// pfq_pkg: shared types and constants for the port flap quarantine block
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package pfq_pkg;

  localparam int EVENT_DEPTH = 64;
  localparam int PTR_W = $clog2(EVENT_DEPTH);
  localparam int CNT_W = $clog2(EVENT_DEPTH + 1);

  localparam int TIME_W = 64;
  localparam int WIN_MIN_W = 11;
  localparam int THR_W = 7;
  localparam int US_PER_MIN_W = 26;
  localparam int WIN_US_W = WIN_MIN_W + US_PER_MIN_W;
  localparam logic [US_PER_MIN_W-1:0] US_PER_MIN = US_PER_MIN_W'(60 * 1000000);

  localparam logic [WIN_MIN_W-1:0] WINDOW_RESET = WIN_MIN_W'(10);
  localparam logic [THR_W-1:0] HIGH_RESET = THR_W'(8);
  localparam logic [THR_W-1:0] LOW_RESET = THR_W'(2);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW = 2'd2;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_FLAP = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  typedef enum logic [1:0] {
    MODE_UNMON = 2'd0,
    MODE_MON   = 2'd1,
    MODE_QUAR  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    TR_NONE      = 2'd0,
    TR_MON_QUAR  = 2'd1,
    TR_MON_UNMON = 2'd2,
    TR_QUAR_MON  = 2'd3
  } trans_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_AGE,
    ST_THR,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ sv/pfq_channels.sv @@
// pfq_channels: valid/ready channel interfaces for items, results and config writes
// depends on pfq_pkg for field widths
`default_nettype none

interface pfq_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [pfq_pkg::TIME_W-1:0]  now_us;
  modport source (output valid, kind, now_us, input ready);
  modport sink (input valid, kind, now_us, output ready);
endinterface

interface pfq_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  port_mode;
  logic [1:0]                  transition;
  logic [6:0]                  held_count;
  logic                        event_dropped;
  modport source (output valid, port_mode, transition, held_count, event_dropped,
                  input ready);
  modport sink (input valid, port_mode, transition, held_count, event_dropped,
                output ready);
endinterface

interface pfq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pfq_pkg::CFG_IDX_W-1:0]   index;
  logic [pfq_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/pfq_ram.sv @@
// pfq_ram: generic single-port-write, registered-read RAM
// no dependencies
`default_nettype none

module pfq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ sv/port_flap_quarantine_top.sv @@
// port_flap_quarantine_top: link flap dampening over a sliding window for one port
// depends on pfq_pkg, pfq_channels (interfaces) and pfq_ram
//
// Channels: item (kind, now_us) in, result (port_mode, transition, held_count,
// event_dropped) out, cfg (index, data) for the three registers. Each is a
// valid/ready channel; a transfer happens when both are high at a rising edge.
// Event times live in a 64-entry RAM with a registered read.
// Steps: a flap, start or reserved kind passes EXEC and then DONE; a tick
// passes EXEC, AGE, THR and DONE, staying in AGE to pop stale entries from
// the FIFO head one at a time, set by the single RAM read port walking the head.
// One item is in flight at a time; item.ready is high only while idle, so the
// next item can be taken as soon as the previous result is registered, even
// while that result still waits on the receiver.
// A stalled receiver holds the result register; a finished item then waits
// in its last step and no further item is taken.
// Reset (synchronous, rst high) clears the mode, FIFO pointers and start times
// and loads the register defaults: window 10 minutes, high 8, low 2.
// The cfg channel is always ready; writes to an unused index are ignored.
// There is no clearing pass: FIFO entries are only read after being written.
`default_nettype none

module port_flap_quarantine_top (
  input  wire logic  clk,
  input  wire logic  rst,
  pfq_in_if.sink     item,
  pfq_out_if.source  result,
  pfq_cfg_if.sink    cfg
);

  pfq_pkg::state_t state, state_next;
  pfq_pkg::mode_t mode, mode_next;
  pfq_pkg::trans_t trans, trans_next;
  logic dropped, dropped_next;

  logic [pfq_pkg::PTR_W-1:0] head, head_next;
  logic [pfq_pkg::CNT_W-1:0] fill, fill_next;
  logic [pfq_pkg::TIME_W-1:0] mon_start, mon_start_next;
  logic [pfq_pkg::TIME_W-1:0] quar_start, quar_start_next;
  logic [pfq_pkg::TIME_W-1:0] win_begin, win_begin_next;
  logic [1:0] cur_kind, cur_kind_next;
  logic [pfq_pkg::TIME_W-1:0] cur_now, cur_now_next;

  logic [pfq_pkg::WIN_MIN_W-1:0] window_minutes;
  logic [pfq_pkg::THR_W-1:0] high_thr, low_thr;
  logic [pfq_pkg::WIN_US_W-1:0] win_us;

  logic res_valid, res_valid_next;
  logic [1:0] res_mode, res_mode_next;
  logic [1:0] res_trans, res_trans_next;
  logic [6:0] res_count, res_count_next;
  logic res_dropped, res_dropped_next;

  logic ram_we;
  logic [pfq_pkg::PTR_W-1:0] ram_wr_addr;
  logic [pfq_pkg::TIME_W-1:0] ram_rd_data;
  logic [pfq_pkg::CNT_W:0] tail_sum;
  logic pop;
  logic slot_free;

  pfq_ram #(
    .WIDTH(pfq_pkg::TIME_W),
    .DEPTH(pfq_pkg::EVENT_DEPTH)
  ) u_event_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (cur_now),
    .rd_addr (head_next),
    .rd_data (ram_rd_data)
  );

  // config registers and scaled window
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_minutes <= pfq_pkg::WINDOW_RESET;
      high_thr <= pfq_pkg::HIGH_RESET;
      low_thr <= pfq_pkg::LOW_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pfq_pkg::CFG_WINDOW: window_minutes <= cfg.data[pfq_pkg::WIN_MIN_W-1:0];
        pfq_pkg::CFG_HIGH: high_thr <= cfg.data[pfq_pkg::THR_W-1:0];
        pfq_pkg::CFG_LOW: low_thr <= cfg.data[pfq_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    win_us <= pfq_pkg::WIN_US_W'(window_minutes) * pfq_pkg::WIN_US_W'(pfq_pkg::US_PER_MIN);
  end

  // tail slot, wrapping at the fifo depth
  always_comb begin
    tail_sum = (pfq_pkg::CNT_W + 1)'(head) + (pfq_pkg::CNT_W + 1)'(fill);
    if (tail_sum >= (pfq_pkg::CNT_W + 1)'(pfq_pkg::EVENT_DEPTH)) begin
      tail_sum = tail_sum - (pfq_pkg::CNT_W + 1)'(pfq_pkg::EVENT_DEPTH);
    end
    ram_wr_addr = tail_sum[pfq_pkg::PTR_W-1:0];
  end

  assign item.ready = (state == pfq_pkg::ST_IDLE);
  assign slot_free = !res_valid || result.ready;
  assign pop = (state == pfq_pkg::ST_AGE) && (fill != '0) && (ram_rd_data < win_begin);

  always_comb begin
    state_next = state;
    mode_next = mode;
    trans_next = trans;
    dropped_next = dropped;
    head_next = head;
    fill_next = fill;
    mon_start_next = mon_start;
    quar_start_next = quar_start;
    win_begin_next = win_begin;
    cur_kind_next = cur_kind;
    cur_now_next = cur_now;
    res_valid_next = res_valid && !result.ready;
    res_mode_next = res_mode;
    res_trans_next = res_trans;
    res_count_next = res_count;
    res_dropped_next = res_dropped;
    ram_we = 1'b0;

    unique case (state)
      pfq_pkg::ST_IDLE: begin
        if (item.valid) begin
          cur_kind_next = item.kind;
          cur_now_next = item.now_us;
          state_next = pfq_pkg::ST_EXEC;
        end
      end
      pfq_pkg::ST_EXEC: begin
        trans_next = pfq_pkg::TR_NONE;
        dropped_next = 1'b0;
        state_next = pfq_pkg::ST_DONE;
        unique case (cur_kind)
          pfq_pkg::KIND_FLAP: begin
            if (mode != pfq_pkg::MODE_UNMON) begin
              if (fill < pfq_pkg::CNT_W'(pfq_pkg::EVENT_DEPTH)) begin
                ram_we = 1'b1;
                fill_next = fill + 1'b1;
              end else begin
                dropped_next = 1'b1;
              end
            end
          end
          pfq_pkg::KIND_START: begin
            if (mode == pfq_pkg::MODE_UNMON) begin
              mode_next = pfq_pkg::MODE_MON;
              mon_start_next = cur_now;
              head_next = '0;
              fill_next = '0;
            end
          end
          pfq_pkg::KIND_TICK: begin
            win_begin_next = cur_now - pfq_pkg::TIME_W'(win_us);
            state_next = pfq_pkg::ST_AGE;
          end
          default: ;
        endcase
      end
      pfq_pkg::ST_AGE: begin
        if (pop) begin
          head_next = (head == pfq_pkg::PTR_W'(pfq_pkg::EVENT_DEPTH - 1)) ? '0 : head + 1'b1;
          fill_next = fill - 1'b1;
        end else begin
          state_next = pfq_pkg::ST_THR;
        end
      end
      pfq_pkg::ST_THR: begin
        state_next = pfq_pkg::ST_DONE;
        priority if (mode == pfq_pkg::MODE_MON) begin
          if (32'(fill) >= 32'(high_thr)) begin
            mode_next = pfq_pkg::MODE_QUAR;
            quar_start_next = cur_now;
            trans_next = pfq_pkg::TR_MON_QUAR;
          end else if (32'(fill) <= 32'(low_thr) && win_begin >= mon_start) begin
            mode_next = pfq_pkg::MODE_UNMON;
            head_next = '0;
            fill_next = '0;
            trans_next = pfq_pkg::TR_MON_UNMON;
          end
        end else if (mode == pfq_pkg::MODE_QUAR) begin
          if (32'(fill) <= 32'(low_thr) && win_begin >= quar_start) begin
            mode_next = pfq_pkg::MODE_MON;
            mon_start_next = cur_now;
            trans_next = pfq_pkg::TR_QUAR_MON;
          end
        end else begin
        end
      end
      pfq_pkg::ST_DONE: begin
        if (slot_free) begin
          res_valid_next = 1'b1;
          res_mode_next = mode;
          res_trans_next = trans;
          res_count_next = 7'(fill);
          res_dropped_next = dropped;
          state_next = pfq_pkg::ST_IDLE;
        end
      end
      default: state_next = pfq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfq_pkg::ST_IDLE;
      mode <= pfq_pkg::MODE_UNMON;
      head <= '0;
      fill <= '0;
      mon_start <= '0;
      quar_start <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      mode <= mode_next;
      head <= head_next;
      fill <= fill_next;
      mon_start <= mon_start_next;
      quar_start <= quar_start_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    trans <= trans_next;
    dropped <= dropped_next;
    win_begin <= win_begin_next;
    cur_kind <= cur_kind_next;
    cur_now <= cur_now_next;
    res_mode <= res_mode_next;
    res_trans <= res_trans_next;
    res_count <= res_count_next;
    res_dropped <= res_dropped_next;
  end

  assign result.valid = res_valid;
  assign result.port_mode = res_mode;
  assign result.transition = res_trans;
  assign result.held_count = res_count;
  assign result.event_dropped = res_dropped;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= pfq_pkg::CNT_W'(pfq_pkg::EVENT_DEPTH))
    else $error("fifo fill above depth");

  a_unmon_empty: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.transition == pfq_pkg::TR_MON_UNMON |-> result.held_count == 7'd0)
    else $error("unmonitor transition with nonempty fifo");

  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    pop |=> fill == $past(fill) - 1'b1)
    else $error("pop did not decrement fill");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> state == pfq_pkg::ST_EXEC)
    else $error("item transfer did not start execution");

  a_unmon_no_events: assert property (@(posedge clk) disable iff (rst)
    mode == pfq_pkg::MODE_UNMON && $past(mode) == pfq_pkg::MODE_UNMON && !$past(rst)
    |-> fill <= $past(fill))
    else $error("fifo grew while unmonitored");
`endif

endmodule

`default_nettype wire

@@ bench/port_flap_quarantine_top_tb.sv @@
// port_flap_quarantine_top_tb: self-checking bench for the port flap quarantine block
// drives item and cfg channels, predicts every result and checks it field by field
// depends on pfq_pkg, pfq_channels and port_flap_quarantine_top

typedef struct packed {
  pfq_pkg::mode_t                 port_mode;
  pfq_pkg::trans_t                transition;
  logic [pfq_pkg::CNT_W-1:0]      held_count;
  logic                           event_dropped;
} port_status_t;

class flap_window_scoreboard;
  logic [pfq_pkg::TIME_W-1:0]    ev_time [pfq_pkg::EVENT_DEPTH];
  logic [pfq_pkg::PTR_W-1:0]     head;
  logic [pfq_pkg::CNT_W-1:0]     fill;
  pfq_pkg::mode_t                mode;
  logic [pfq_pkg::TIME_W-1:0]    mon_since;
  logic [pfq_pkg::TIME_W-1:0]    quar_since;
  logic [pfq_pkg::WIN_MIN_W-1:0] win_min;
  logic [pfq_pkg::THR_W-1:0]     thr_high;
  logic [pfq_pkg::THR_W-1:0]     thr_low;
  port_status_t                  port_status_q [$];
  int                            errors;

  function new();
    head = '0;
    fill = '0;
    mode = pfq_pkg::MODE_UNMON;
    mon_since = '0;
    quar_since = '0;
    win_min = pfq_pkg::WINDOW_RESET;
    thr_high = pfq_pkg::HIGH_RESET;
    thr_low = pfq_pkg::LOW_RESET;
    errors = 0;
  endfunction

  function void set_reg(logic [pfq_pkg::CFG_IDX_W-1:0] idx,
                        logic [pfq_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      pfq_pkg::CFG_WINDOW: win_min = data[pfq_pkg::WIN_MIN_W-1:0];
      pfq_pkg::CFG_HIGH:   thr_high = data[pfq_pkg::THR_W-1:0];
      pfq_pkg::CFG_LOW:    thr_low = data[pfq_pkg::THR_W-1:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return port_status_q.size();
  endfunction

  function void note_item(logic [1:0] kind, logic [pfq_pkg::TIME_W-1:0] now);
    port_status_t st;
    logic [pfq_pkg::TIME_W-1:0] win_start;
    st.transition = pfq_pkg::TR_NONE;
    st.event_dropped = 1'b0;
    case (kind)
      pfq_pkg::KIND_FLAP: begin
        if (mode != pfq_pkg::MODE_UNMON) begin
          if (fill < pfq_pkg::EVENT_DEPTH) begin
            ev_time[head + fill[pfq_pkg::PTR_W-1:0]] = now;
            fill = fill + 1'b1;
          end else begin
            st.event_dropped = 1'b1;
          end
        end
      end
      pfq_pkg::KIND_START: begin
        if (mode == pfq_pkg::MODE_UNMON) begin
          mode = pfq_pkg::MODE_MON;
          mon_since = now;
          head = '0;
          fill = '0;
        end
      end
      pfq_pkg::KIND_TICK: begin
        win_start = now - 64'(win_min) * 64'(pfq_pkg::US_PER_MIN);
        while (fill != 0 && ev_time[head] < win_start) begin
          head = head + 1'b1;
          fill = fill - 1'b1;
        end
        if (mode == pfq_pkg::MODE_MON) begin
          if (fill >= thr_high) begin
            mode = pfq_pkg::MODE_QUAR;
            quar_since = now;
            st.transition = pfq_pkg::TR_MON_QUAR;
          end else if (fill <= thr_low && win_start >= mon_since) begin
            mode = pfq_pkg::MODE_UNMON;
            head = '0;
            fill = '0;
            st.transition = pfq_pkg::TR_MON_UNMON;
          end
        end else if (mode == pfq_pkg::MODE_QUAR) begin
          if (fill <= thr_low && win_start >= quar_since) begin
            mode = pfq_pkg::MODE_MON;
            mon_since = now;
            st.transition = pfq_pkg::TR_QUAR_MON;
          end
        end
      end
      default: ;
    endcase
    st.port_mode = mode;
    st.held_count = fill;
    port_status_q.push_back(st);
  endfunction

  function void cmp(string field, logic [6:0] exp_v, logic [6:0] act_v, longint unsigned at);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0d ns: %s expected %0d got %0d", at, field, exp_v, act_v);
    end
  endfunction

  function void check_result(logic [1:0] pm, logic [1:0] tr, logic [6:0] cnt, logic drop,
                             longint unsigned at);
    port_status_t st;
    if (port_status_q.size() == 0) begin
      errors++;
      $display("%0d ns: result with no item pending, expected none got mode %0d count %0d",
               at, pm, cnt);
    end else begin
      st = port_status_q.pop_front();
      cmp("port_mode", 7'(st.port_mode), 7'(pm), at);
      cmp("transition", 7'(st.transition), 7'(tr), at);
      cmp("held_count", st.held_count, cnt, at);
      cmp("event_dropped", 7'(st.event_dropped), 7'(drop), at);
    end
  endfunction
endclass

module port_flap_quarantine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam logic [pfq_pkg::CFG_IDX_W-1:0] CFG_RESERVED = 2'd3;
  localparam int RUN_LIMIT = 1_500_000;
  localparam logic [63:0] WIN_DEFAULT_US = 64'd600_000_000;

  logic clk = 1'b0;
  logic rst;
  int   cycles = 0;
  bit   hold_request = 1'b0;
  bit   no_gaps = 1'b0;
  logic [63:0] cur_t;
  logic [63:0] span;

  flap_window_scoreboard sb = new();

  pfq_in_if  item_ch ();
  pfq_out_if result_ch ();
  pfq_cfg_if cfg_ch ();

  port_flap_quarantine_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.port_mode, result_ch.transition, result_ch.held_count,
                      result_ch.event_dropped, $time);
  end

  // receiver: random stalls, free-running stretches and one long hold on request
  initial begin
    int hold;
    int regime_left;
    bit free_run;
    int r;
    result_ch.ready = 1'b0;
    hold = 0;
    regime_left = 0;
    free_run = 1'b0;
    forever begin
      @(negedge clk);
      if (regime_left == 0) begin
        free_run = ($urandom_range(0, 3) == 0);
        regime_left = 256;
      end
      regime_left--;
      if (hold_request) begin
        hold_request = 1'b0;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        result_ch.ready <= 1'b0;
      end else if (free_run) begin
        result_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          result_ch.ready <= 1'b1;
        end else begin
          result_ch.ready <= 1'b0;
          hold = (r < 96) ? $urandom_range(0, 2) : $urandom_range(20, 60);
        end
      end
    end
  end

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand_below(logic [63:0] lim);
    return {$urandom, $urandom} % (lim + 64'd1);
  endfunction

  task automatic idle_for(input int n);
    if (n > 0) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_item(input logic [1:0] kind, input logic [63:0] t);
    @(negedge clk);
    item_ch.valid <= 1'b1;
    item_ch.kind <= kind;
    item_ch.now_us <= t;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_item(kind, t);
    idle_for(gap_len());
  endtask

  task automatic write_reg(input logic [pfq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pfq_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int ph, input int count);
    int storm_left;
    int r;
    int r2;
    logic [1:0] kind;
    logic [63:0] t;
    storm_left = 0;
    for (int i = 0; i < count; i++) begin
      if (ph == 2 && i == 10) hold_request = 1'b1;
      if (ph == 5 && i == 50) wait_drained();
      r = $urandom_range(0, 99);
      if (storm_left == 0 && sb.mode != pfq_pkg::MODE_UNMON && $urandom_range(0, 99) < 3)
        storm_left = $urandom_range(40, 90);
      if (storm_left > 0) begin
        // flap storm: dense events to reach the thresholds and overflow the fifo
        storm_left--;
        kind = ($urandom_range(0, 19) == 0) ? pfq_pkg::KIND_TICK : pfq_pkg::KIND_FLAP;
        cur_t = cur_t + rand_below(span >> 8);
        t = cur_t;
      end else if (r < 4) begin
        kind = 2'($urandom);
        t = {$urandom, $urandom};
      end else begin
        case (sb.mode)
          pfq_pkg::MODE_UNMON:
            kind = (r < 60) ? pfq_pkg::KIND_START : (r < 80) ? pfq_pkg::KIND_TICK :
                   pfq_pkg::KIND_FLAP;
          pfq_pkg::MODE_MON:
            kind = (r < 50) ? pfq_pkg::KIND_FLAP : (r < 92) ? pfq_pkg::KIND_TICK :
                   (r < 96) ? pfq_pkg::KIND_START : KIND_RESERVED;
          default:
            kind = (r < 30) ? pfq_pkg::KIND_FLAP : (r < 94) ? pfq_pkg::KIND_TICK :
                   (r < 97) ? pfq_pkg::KIND_START : KIND_RESERVED;
        endcase
        r2 = $urandom_range(0, 99);
        if (r2 < 65) cur_t = cur_t + rand_below(span >> $urandom_range(3, 6));
        else if (r2 < 90) cur_t = cur_t + rand_below(span);
        else if (r2 < 98) cur_t = cur_t + span + rand_below(span * 2);
        else cur_t = {$urandom, $urandom};
        t = cur_t;
      end
      send_item(kind, t);
    end
  endtask

  initial begin
    logic [63:0] t1;
    logic [63:0] t2;
    int w;
    int h;
    int l;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.kind = pfq_pkg::KIND_TICK;
    item_ch.now_us = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = pfq_pkg::CFG_WINDOW;
    cfg_ch.data = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // reset settings: reserved kind, unmonitored cases, start, unmonitor
    t1 = 64'h0000_0100_0000_0000;
    send_item(KIND_RESERVED, 64'd0);
    send_item(pfq_pkg::KIND_FLAP, '1);
    send_item(pfq_pkg::KIND_TICK, 64'd0);
    send_item(pfq_pkg::KIND_START, t1);
    send_item(pfq_pkg::KIND_START, t1 + 64'd100);
    send_item(pfq_pkg::KIND_FLAP, t1 + 64'd200);
    send_item(pfq_pkg::KIND_FLAP, t1 + 64'd300);
    send_item(pfq_pkg::KIND_TICK, t1 + 64'd400);
    send_item(pfq_pkg::KIND_TICK, t1 + WIN_DEFAULT_US + 64'd1000);

    // quarantine, release and an out-of-order timestamp at the head
    wait_drained();
    write_reg(pfq_pkg::CFG_HIGH, 11'd3);
    write_reg(pfq_pkg::CFG_LOW, 11'd1);
    t2 = t1 + 64'd10_000_000_000;
    send_item(pfq_pkg::KIND_START, t2);
    send_item(pfq_pkg::KIND_FLAP, t2 + 64'd1);
    send_item(pfq_pkg::KIND_FLAP, t2 + 64'd2);
    send_item(pfq_pkg::KIND_FLAP, t2 + 64'd3);
    send_item(KIND_RESERVED, t2 + 64'd4);
    send_item(pfq_pkg::KIND_TICK, t2 + 64'd5);
    send_item(pfq_pkg::KIND_FLAP, '1);
    send_item(pfq_pkg::KIND_START, t2 + 64'd6);
    send_item(pfq_pkg::KIND_TICK, t2 + WIN_DEFAULT_US + 64'd100);
    send_item(pfq_pkg::KIND_FLAP, 64'd0);
    send_item(pfq_pkg::KIND_TICK, t2 + WIN_DEFAULT_US + 64'd200);

    for (int ph = 0; ph < 12; ph++) begin
      wait_drained();
      case (ph)
        0: begin w = 1; h = 1; l = 0; end
        1: begin w = 1440; h = 64; l = 64; end
        2: begin w = 2047; h = 0; l = 127; end
        3: begin w = 0; h = 127; l = 0; end
        default: begin
          w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 1440);
          h = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
          l = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, h);
        end
      endcase
      if (ph == 0) write_reg(CFG_RESERVED, '1);
      write_reg(pfq_pkg::CFG_WINDOW, 11'(w));
      write_reg(pfq_pkg::CFG_HIGH, {4'($urandom), 7'(h)});
      write_reg(pfq_pkg::CFG_LOW, {4'($urandom), 7'(l)});
      span = (w == 0) ? 64'd5000 : 64'(w) * 64'(pfq_pkg::US_PER_MIN);
      if ($urandom_range(0, 4) == 0) cur_t = 64'hFFFF_FFFF_FFFF_FFFF - rand_below(span * 4);
      else cur_t = {$urandom, $urandom} >> $urandom_range(0, 24);
      no_gaps = ($urandom_range(0, 3) == 0);
      run_phase(ph, 110);
    end

    wait_drained();
    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
